[design/rrts_pkg.sv]
// Package for the round-robin thread scheduler: request/response beat types,
// thread state codes, request and status codes, sequencer states. No dependencies.
package rrts_pkg;

   localparam int ThreadSlotsDefault = 16;

   typedef enum logic [2:0] {
      REQ_SPAWN     = 3'd0,
      REQ_TERMINATE = 3'd1,
      REQ_BLOCK     = 3'd2,
      REQ_RESUME    = 3'd3,
      REQ_SLEEP     = 3'd4,
      REQ_TICK      = 3'd5,
      REQ_RSVD6     = 3'd6,
      REQ_RSVD7     = 3'd7
   } req_code_type;

   typedef enum logic [2:0] {
      ST_FREE    = 3'd0,
      ST_RUNNING = 3'd1,
      ST_READY   = 3'd2,
      ST_BLOCKED = 3'd3,
      ST_SLEEP   = 3'd4,
      ST_BSLEEP  = 3'd5
   } thr_state_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_NO_THREAD = 3'd1,
      STS_MAIN      = 3'd2,
      STS_NO_FREE   = 3'd3,
      STS_NULL      = 3'd4
   } status_code_type;

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_DECODE,
      SQ_SPAWN_SCAN,
      SQ_RM_FIND,
      SQ_RM_SHIFT,
      SQ_WAKE_SCAN,
      SQ_REQUEUE,
      SQ_POP,
      SQ_CLEAR,
      SQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  thread_id;
      logic [31:0] entry_addr;
      logic [15:0] sleep_quanta;
   } req_beat_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  new_tid;
      logic [3:0]  current_tid;
      logic [31:0] quanta_total;
      logic        shutdown;
   } rsp_beat_type;

endpackage

[design/rrts_ring.sv]
// Ready ring: FIFO of thread ids in a small memory with one read and one
// write port. No dependencies.
module rrts_ring #(
   parameter int Slots = 16,
   localparam int IdW = (Slots > 1) ? $clog2(Slots) : 1
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [IdW-1:0] wr_addr,
   input  logic [IdW-1:0] wr_data,
   input  logic [IdW-1:0] rd_addr,
   output logic [IdW-1:0] rd_data_ff
);
   logic [IdW-1:0] mem [Slots];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end
endmodule

[design/round_robin_thread_scheduler.sv]
// Round-robin thread scheduler, top level: sequencer, thread table, ring control.
// Depends on rrts_pkg and rrts_ring.
//
// One request at a time. Each request is decoded, then spawn and every switch scan
// the thread table (one slot per cycle), and removing a ready thread from the ring
// walks the ring entries through the find and shift states. The single wake-time
// comparator and the single-read-port ring memory set these costs. Terminating
// thread 0 sweeps the thread table back to reset, one slot per cycle, before the
// response beat. req_stall is high from acceptance until the response beat has
// been taken.
module round_robin_thread_scheduler #(
   parameter int THREAD_SLOTS = rrts_pkg::ThreadSlotsDefault,
   localparam int IdW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1,
   localparam int CntW = $clog2(THREAD_SLOTS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rrts_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rrts_pkg::rsp_beat_type rsp_data
);
   localparam logic [IdW-1:0] LastId = IdW'(THREAD_SLOTS - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(THREAD_SLOTS);

   // thread table
   rrts_pkg::thr_state_type st_ff [THREAD_SLOTS];
   logic [31:0] wake_mem [THREAD_SLOTS];
   logic [31:0] entry_mem [THREAD_SLOTS];

   // control registers
   rrts_pkg::seq_state_type state_ff, state_in;
   rrts_pkg::req_beat_type  req_ff;
   logic [IdW-1:0]  head_ff, active_ff, idx_ff, find_ff;
   logic [CntW-1:0] count_ff, k_ff;
   logic [31:0]     qc_ff;
   logic [2:0]      status_ff;
   logic [IdW-1:0]  new_tid_ff;
   logic            shut_ff;
   // ring removal walk: find_ff holds the matching position, fnd_ff marks it valid
   logic            fnd_ff;
   // head was written by the requeue of an empty ring, so the read is stale
   logic            pop_byp_ff;
   logic [IdW-1:0]  pop_id;

   // ring memory wires
   logic           rwr_en;
   logic [IdW-1:0] rwr_addr, rwr_data, rrd_addr, rrd_data_ff;

   rrts_ring #(.Slots(THREAD_SLOTS)) u_ring (
      .clock(clock), .wr_en(rwr_en), .wr_addr(rwr_addr), .wr_data(rwr_data),
      .rd_addr(rrd_addr), .rd_data_ff(rrd_data_ff)
   );

   function automatic logic [IdW-1:0] rpos(input logic [IdW-1:0] h,
                                           input logic [CntW-1:0] k);
      logic [CntW:0] p;
      p = (CntW+1)'(h) + (CntW+1)'(k);
      if (p >= (CntW+1)'(THREAD_SLOTS)) p = p - (CntW+1)'(THREAD_SLOTS);
      return p[IdW-1:0];
   endfunction

   // decode view of the request
   logic [IdW-1:0] tid;
   logic           tid_ok, exists, is_act;
   rrts_pkg::thr_state_type tst;
   always_comb begin
      tid_ok = ({28'd0, req_ff.thread_id} < 32'(THREAD_SLOTS));
      tid    = IdW'(req_ff.thread_id);
      tst    = st_ff[tid];
      exists = tid_ok && (tst != rrts_pkg::ST_FREE);
      is_act = tid_ok && (tid == active_ff);
   end

   logic scan_last, find_last;
   assign scan_last = (idx_ff == LastId);
   assign find_last = (k_ff + CntW'(1) >= count_ff);
   assign pop_id    = pop_byp_ff ? active_ff : rrd_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrts_pkg::SQ_IDLE:
            if (req_valid) state_in = rrts_pkg::SQ_DECODE;
         rrts_pkg::SQ_DECODE: begin
            state_in = rrts_pkg::SQ_DONE;
            case (req_ff.req_type)
               rrts_pkg::REQ_SPAWN:
                  if (req_ff.entry_addr != 32'd0) state_in = rrts_pkg::SQ_SPAWN_SCAN;
               rrts_pkg::REQ_TERMINATE:
                  if (exists && tid == '0) state_in = rrts_pkg::SQ_CLEAR;
                  else if (exists && tst == rrts_pkg::ST_READY)
                     state_in = rrts_pkg::SQ_RM_FIND;
                  else if (exists && is_act) state_in = rrts_pkg::SQ_WAKE_SCAN;
               rrts_pkg::REQ_BLOCK:
                  if (exists && tid != '0) begin
                     if (is_act) state_in = rrts_pkg::SQ_WAKE_SCAN;
                     else if (tst == rrts_pkg::ST_READY) state_in = rrts_pkg::SQ_RM_FIND;
                  end
               rrts_pkg::REQ_SLEEP:
                  if (active_ff != '0) state_in = rrts_pkg::SQ_WAKE_SCAN;
               rrts_pkg::REQ_TICK:
                  state_in = rrts_pkg::SQ_WAKE_SCAN;
               default: state_in = rrts_pkg::SQ_DONE;
            endcase
         end
         rrts_pkg::SQ_SPAWN_SCAN:
            if (st_ff[idx_ff] == rrts_pkg::ST_FREE || scan_last)
               state_in = rrts_pkg::SQ_DONE;
         rrts_pkg::SQ_RM_FIND:
            if (count_ff == '0) state_in = rrts_pkg::SQ_DONE;
            else state_in = rrts_pkg::SQ_RM_SHIFT;
         rrts_pkg::SQ_RM_SHIFT:
            if (find_last) begin
               if (req_ff.req_type == rrts_pkg::REQ_TERMINATE && is_act)
                  state_in = rrts_pkg::SQ_WAKE_SCAN;
               else state_in = rrts_pkg::SQ_DONE;
            end else state_in = rrts_pkg::SQ_RM_FIND;
         rrts_pkg::SQ_WAKE_SCAN:
            if (scan_last) state_in = rrts_pkg::SQ_REQUEUE;
         rrts_pkg::SQ_REQUEUE:
            state_in = rrts_pkg::SQ_POP;
         rrts_pkg::SQ_POP:
            state_in = rrts_pkg::SQ_DONE;
         rrts_pkg::SQ_CLEAR:
            if (scan_last) state_in = rrts_pkg::SQ_DONE;
         rrts_pkg::SQ_DONE:
            if (!rsp_stall) state_in = rrts_pkg::SQ_IDLE;
         default: state_in = rrts_pkg::SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rrts_pkg::SQ_IDLE;
      else state_ff <= state_in;
   end

   // ring port selection
   logic push_en;
   logic [IdW-1:0] push_id;
   logic wake_hit;
   assign wake_hit = (wake_mem[idx_ff] == qc_ff);
   always_comb begin
      push_en = 1'b0;
      push_id = idx_ff;
      case (state_ff)
         rrts_pkg::SQ_SPAWN_SCAN:
            push_en = (st_ff[idx_ff] == rrts_pkg::ST_FREE);
         rrts_pkg::SQ_WAKE_SCAN:
            push_en = (st_ff[idx_ff] == rrts_pkg::ST_SLEEP) && wake_hit;
         rrts_pkg::SQ_REQUEUE: begin
            push_en = (st_ff[active_ff] == rrts_pkg::ST_RUNNING);
            push_id = active_ff;
         end
         rrts_pkg::SQ_DECODE:
            if (req_ff.req_type == rrts_pkg::REQ_RESUME && exists &&
                tst == rrts_pkg::ST_BLOCKED) begin
               push_en = 1'b1;
               push_id = tid;
            end
         default: push_en = 1'b0;
      endcase
      push_en  = push_en && (count_ff < FullCnt);
      rwr_en   = push_en;
      rwr_addr = rpos(head_ff, count_ff);
      rwr_data = push_id;
      rrd_addr = head_ff;
      // entries behind the match move up one place
      if (state_ff == rrts_pkg::SQ_RM_SHIFT) begin
         rwr_en   = fnd_ff && (k_ff > CntW'(find_ff));
         rwr_addr = rpos(head_ff, k_ff - CntW'(1));
         rwr_data = rrd_data_ff;
      end
      if (state_ff == rrts_pkg::SQ_RM_FIND || state_ff == rrts_pkg::SQ_RM_SHIFT)
         rrd_addr = rpos(head_ff, k_ff + CntW'(1));
      if (state_ff == rrts_pkg::SQ_DECODE || state_ff == rrts_pkg::SQ_RM_FIND)
         rrd_addr = rpos(head_ff, (state_ff == rrts_pkg::SQ_DECODE) ? '0 : k_ff);
   end

   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < THREAD_SLOTS; i++)
            st_ff[i] <= (i == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_FREE;
         head_ff   <= '0;
         count_ff  <= '0;
         active_ff <= '0;
         qc_ff     <= 32'd1;
         idx_ff    <= '0;
         k_ff      <= '0;
         find_ff   <= '0;
         fnd_ff    <= 1'b0;
         pop_byp_ff <= 1'b0;
         shut_ff   <= 1'b0;
         status_ff <= rrts_pkg::STS_OK;
         new_tid_ff <= '0;
      end else begin
         if (push_en) count_ff <= count_ff + CntW'(1);
         pop_byp_ff <= (state_ff == rrts_pkg::SQ_REQUEUE) && push_en && (count_ff == '0);
         case (state_ff)
            rrts_pkg::SQ_IDLE:
               if (req_valid) begin
                  req_ff     <= req_data;
                  status_ff  <= rrts_pkg::STS_OK;
                  new_tid_ff <= '0;
                  shut_ff    <= 1'b0;
                  idx_ff     <= '0;
                  k_ff       <= '0;
                  fnd_ff     <= 1'b0;
               end
            rrts_pkg::SQ_DECODE:
               case (req_ff.req_type)
                  rrts_pkg::REQ_SPAWN:
                     status_ff <= (req_ff.entry_addr == 32'd0) ? rrts_pkg::STS_NULL
                                                               : rrts_pkg::STS_NO_FREE;
                  rrts_pkg::REQ_TERMINATE:
                     if (!exists) status_ff <= rrts_pkg::STS_NO_THREAD;
                     else if (tid == '0) shut_ff <= 1'b1;
                     else if (tst != rrts_pkg::ST_READY) st_ff[tid] <= rrts_pkg::ST_FREE;
                  rrts_pkg::REQ_BLOCK:
                     if (!exists) status_ff <= rrts_pkg::STS_NO_THREAD;
                     else if (tid == '0) status_ff <= rrts_pkg::STS_MAIN;
                     else if (is_act) st_ff[tid] <= rrts_pkg::ST_BLOCKED;
                     else if (tst == rrts_pkg::ST_SLEEP) st_ff[tid] <= rrts_pkg::ST_BSLEEP;
                  rrts_pkg::REQ_RESUME:
                     if (!exists) status_ff <= rrts_pkg::STS_NO_THREAD;
                     else if (tst == rrts_pkg::ST_BLOCKED) st_ff[tid] <= rrts_pkg::ST_READY;
                     else if (tst == rrts_pkg::ST_BSLEEP) st_ff[tid] <= rrts_pkg::ST_SLEEP;
                  rrts_pkg::REQ_SLEEP:
                     if (active_ff == '0) status_ff <= rrts_pkg::STS_MAIN;
                     else begin
                        wake_mem[active_ff] <= qc_ff + {16'd0, req_ff.sleep_quanta};
                        st_ff[active_ff]    <= rrts_pkg::ST_SLEEP;
                     end
                  default: status_ff <= rrts_pkg::STS_OK;
               endcase
            rrts_pkg::SQ_SPAWN_SCAN: begin
               if (st_ff[idx_ff] == rrts_pkg::ST_FREE) begin
                  st_ff[idx_ff]     <= rrts_pkg::ST_READY;
                  entry_mem[idx_ff] <= req_ff.entry_addr;
                  new_tid_ff        <= idx_ff;
                  status_ff         <= rrts_pkg::STS_OK;
               end
               idx_ff <= idx_ff + IdW'(1);
            end
            rrts_pkg::SQ_RM_FIND:
               // rrd_data_ff holds ring entry k
               if (!fnd_ff && rrd_data_ff == tid) begin
                  fnd_ff  <= 1'b1;
                  find_ff <= k_ff[IdW-1:0];
               end
            rrts_pkg::SQ_RM_SHIFT: begin
               k_ff <= k_ff + CntW'(1);
               if (find_last) begin
                  if (fnd_ff || rrd_data_ff == tid) count_ff <= count_ff - CntW'(1);
                  st_ff[tid] <= (req_ff.req_type == rrts_pkg::REQ_TERMINATE)
                                ? rrts_pkg::ST_FREE : rrts_pkg::ST_BLOCKED;
               end
            end
            rrts_pkg::SQ_WAKE_SCAN: begin
               if (wake_hit && st_ff[idx_ff] == rrts_pkg::ST_SLEEP)
                  st_ff[idx_ff] <= rrts_pkg::ST_READY;
               else if (wake_hit && st_ff[idx_ff] == rrts_pkg::ST_BSLEEP)
                  st_ff[idx_ff] <= rrts_pkg::ST_BLOCKED;
               idx_ff <= idx_ff + IdW'(1);
               if (scan_last) qc_ff <= qc_ff + 32'd1;
            end
            rrts_pkg::SQ_REQUEUE:
               if (st_ff[active_ff] == rrts_pkg::ST_RUNNING)
                  st_ff[active_ff] <= rrts_pkg::ST_READY;
            rrts_pkg::SQ_POP:
               if (count_ff != '0) begin
                  active_ff <= pop_id;
                  st_ff[pop_id] <= rrts_pkg::ST_RUNNING;
                  head_ff  <= rpos(head_ff, CntW'(1));
                  count_ff <= count_ff - CntW'(1);
               end
            rrts_pkg::SQ_CLEAR: begin
               st_ff[idx_ff] <= (idx_ff == '0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_FREE;
               idx_ff    <= idx_ff + IdW'(1);
               head_ff   <= '0;
               count_ff  <= '0;
               active_ff <= '0;
               qc_ff     <= 32'd1;
            end
            default: begin
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      req_stall            = (state_ff != rrts_pkg::SQ_IDLE);
      rsp_valid            = (state_ff == rrts_pkg::SQ_DONE);
      rsp_data.status      = status_ff;
      rsp_data.new_tid     = 4'(new_tid_ff);
      rsp_data.current_tid = 4'(active_ff);
      rsp_data.quanta_total = qc_ff;
      rsp_data.shutdown    = shut_ff;
   end

   // assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt) else $error("ring count above depth");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while response pending");
   a_qc_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrts_pkg::SQ_IDLE) |=> (qc_ff == $past(qc_ff)))
      else $error("quantum count moved while idle");
   a_shut_reset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && shut_ff) |-> (qc_ff == 32'd1 && active_ff == '0))
      else $error("shutdown without reset state");
endmodule

[bench/tb.sv]
// Testbench for round_robin_thread_scheduler: a directed table, then random request
// streams, checked against typed rows or an in-bench predictor. Uses rrts_pkg.
module tb;

   localparam int Slots = rrts_pkg::ThreadSlotsDefault;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rrts_pkg::req_beat_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rrts_pkg::rsp_beat_type rsp_data;

   round_robin_thread_scheduler #(.THREAD_SLOTS(Slots)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // predictor copy of the scheduler
   rrts_pkg::thr_state_type sched_state[Slots];
   logic [31:0] sched_wake[Slots];
   logic [3:0]  sched_ring[Slots];
   int unsigned sched_head, sched_count;
   logic [3:0]  sched_active;
   logic [31:0] sched_quanta;

   rrts_pkg::rsp_beat_type rsp_expected_q[$];
   int errors = 0;
   bit idle_on = 1'b1;

   function automatic void sched_reset();
      for (int i = 0; i < Slots; i++) begin
         sched_state[i] = rrts_pkg::ST_FREE;
         sched_wake[i] = '0;
         sched_ring[i] = '0;
      end
      sched_state[0] = rrts_pkg::ST_RUNNING;
      sched_head = 0;
      sched_count = 0;
      sched_active = '0;
      sched_quanta = 32'd1;
   endfunction

   function automatic void ring_push(logic [3:0] tid);
      if (sched_count < Slots) begin
         sched_ring[(sched_head + sched_count) % Slots] = tid;
         sched_count++;
      end
   endfunction

   function automatic void ring_drop(logic [3:0] tid);
      int found;
      found = sched_count;
      for (int k = 0; k < sched_count; k++)
         if (found == sched_count && sched_ring[(sched_head + k) % Slots] == tid) found = k;
      if (found != sched_count) begin
         for (int k = found; k + 1 < sched_count; k++)
            sched_ring[(sched_head + k) % Slots] = sched_ring[(sched_head + k + 1) % Slots];
         sched_count--;
      end
   endfunction

   function automatic void sched_switch();
      for (int i = 0; i < Slots; i++) begin
         if (sched_state[i] == rrts_pkg::ST_SLEEP && sched_wake[i] == sched_quanta) begin
            sched_state[i] = rrts_pkg::ST_READY;
            ring_push(4'(i));
         end else if (sched_state[i] == rrts_pkg::ST_BSLEEP &&
                      sched_wake[i] == sched_quanta) begin
            sched_state[i] = rrts_pkg::ST_BLOCKED;
         end
      end
      sched_quanta++;
      if (sched_state[sched_active] == rrts_pkg::ST_RUNNING) begin
         sched_state[sched_active] = rrts_pkg::ST_READY;
         ring_push(sched_active);
      end
      if (sched_count > 0) begin
         sched_active = sched_ring[sched_head];
         sched_head = (sched_head + 1) % Slots;
         sched_count--;
         sched_state[sched_active] = rrts_pkg::ST_RUNNING;
      end
   endfunction

   function automatic rrts_pkg::rsp_beat_type schedule_request(rrts_pkg::req_beat_type r);
      rrts_pkg::rsp_beat_type o;
      logic [3:0] t;
      bit exists;
      o = '0;
      t = r.thread_id;
      exists = sched_state[t] != rrts_pkg::ST_FREE;
      case (rrts_pkg::req_code_type'(r.req_type))
         rrts_pkg::REQ_SPAWN: begin
            if (r.entry_addr == 0) o.status = rrts_pkg::STS_NULL;
            else begin
               o.status = rrts_pkg::STS_NO_FREE;
               for (int i = 0; i < Slots; i++)
                  if (o.status == rrts_pkg::STS_NO_FREE &&
                      sched_state[i] == rrts_pkg::ST_FREE) begin
                     sched_state[i] = rrts_pkg::ST_READY;
                     ring_push(4'(i));
                     o.new_tid = 4'(i);
                     o.status = rrts_pkg::STS_OK;
                  end
            end
         end
         rrts_pkg::REQ_TERMINATE: begin
            if (!exists) o.status = rrts_pkg::STS_NO_THREAD;
            else if (t == 0) begin
               sched_reset();
               o.shutdown = 1'b1;
            end else begin
               if (sched_state[t] == rrts_pkg::ST_READY) ring_drop(t);
               sched_state[t] = rrts_pkg::ST_FREE;
               if (t == sched_active) sched_switch();
            end
         end
         rrts_pkg::REQ_BLOCK: begin
            if (!exists) o.status = rrts_pkg::STS_NO_THREAD;
            else if (t == 0) o.status = rrts_pkg::STS_MAIN;
            else if (t == sched_active) begin
               sched_state[t] = rrts_pkg::ST_BLOCKED;
               sched_switch();
            end else if (sched_state[t] == rrts_pkg::ST_SLEEP)
               sched_state[t] = rrts_pkg::ST_BSLEEP;
            else if (sched_state[t] == rrts_pkg::ST_READY) begin
               sched_state[t] = rrts_pkg::ST_BLOCKED;
               ring_drop(t);
            end
         end
         rrts_pkg::REQ_RESUME: begin
            if (!exists) o.status = rrts_pkg::STS_NO_THREAD;
            else if (sched_state[t] == rrts_pkg::ST_BLOCKED) begin
               sched_state[t] = rrts_pkg::ST_READY;
               ring_push(t);
            end else if (sched_state[t] == rrts_pkg::ST_BSLEEP)
               sched_state[t] = rrts_pkg::ST_SLEEP;
         end
         rrts_pkg::REQ_SLEEP: begin
            if (sched_active == 0) o.status = rrts_pkg::STS_MAIN;
            else begin
               sched_wake[sched_active] = sched_quanta + 32'(r.sleep_quanta);
               sched_state[sched_active] = rrts_pkg::ST_SLEEP;
               sched_switch();
            end
         end
         rrts_pkg::REQ_TICK: sched_switch();
         default: ;
      endcase
      o.current_tid = sched_active;
      o.quanta_total = sched_quanta;
      return o;
   endfunction

   // drive one request beat; queue the given or predicted response
   task automatic send_request(rrts_pkg::req_beat_type r, bit typed,
                               rrts_pkg::rsp_beat_type typed_rsp);
      rrts_pkg::rsp_beat_type p;
      while (idle_on && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = schedule_request(r);
      rsp_expected_q.insert(rsp_expected_q.size(), typed ? typed_rsp : p);
   endtask

   // response side: random stall, compare accepted beats
   always @(posedge clock) begin
      rrts_pkg::rsp_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_expected_q.size() == 0) begin
            $display("%0t: unexpected response expected none actual %h", $time, rsp_data);
            errors++;
         end else begin
            e = rsp_expected_q[0];
            rsp_expected_q.delete(0);
            if (rsp_data.status !== e.status || rsp_data.new_tid !== e.new_tid ||
                rsp_data.current_tid !== e.current_tid ||
                rsp_data.quanta_total !== e.quanta_total ||
                rsp_data.shutdown !== e.shutdown) begin
               $display("%0t: mismatch expected %h actual %h", $time, e, rsp_data);
               errors++;
            end
         end
      end
      rsp_stall <= idle_on ? ($urandom_range(99) < 34) : 1'b0;
   end

   function automatic rrts_pkg::req_beat_type mk(rrts_pkg::req_code_type c, logic [3:0] t,
                                                 logic [31:0] a, logic [15:0] q);
      rrts_pkg::req_beat_type r;
      r.req_type = c;
      r.thread_id = t;
      r.entry_addr = a;
      r.sleep_quanta = q;
      return r;
   endfunction

   function automatic rrts_pkg::rsp_beat_type rs(rrts_pkg::status_code_type s,
                                                 logic [3:0] n, logic [3:0] c,
                                                 logic [31:0] q, logic sd);
      rrts_pkg::rsp_beat_type o;
      o.status = s;
      o.new_tid = n;
      o.current_tid = c;
      o.quanta_total = q;
      o.shutdown = sd;
      return o;
   endfunction

   // directed table: typed rows carry their response
   typedef struct {
      rrts_pkg::req_beat_type rq;
      bit typed;
      rrts_pkg::rsp_beat_type rp;
   } stim_row_type;

   stim_row_type dir_rows[$];

   function automatic void add_row(rrts_pkg::req_beat_type rq, bit typed,
                                   rrts_pkg::rsp_beat_type rp);
      stim_row_type row;
      row.rq = rq;
      row.typed = typed;
      row.rp = rp;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   function automatic logic [3:0] live_tid();
      logic [3:0] t;
      t = 4'($urandom_range(Slots - 1));
      for (int k = 0; k < Slots; k++)
         if (sched_state[(t + k) % Slots] != rrts_pkg::ST_FREE && (t + k) % Slots != 0)
            return 4'((t + k) % Slots);
      return t;
   endfunction

   function automatic rrts_pkg::req_beat_type random_request();
      rrts_pkg::req_beat_type r;
      int sel;
      r.req_type = 3'($urandom_range(7));
      r.thread_id = 4'($urandom_range(15));
      r.entry_addr = $urandom;
      r.sleep_quanta = 16'($urandom);
      sel = $urandom_range(99);
      if (sel < 20) begin
         r.req_type = rrts_pkg::REQ_SPAWN;
         if ($urandom_range(19) == 0) r.entry_addr = '0;
      end else if (sel < 32) r.req_type = rrts_pkg::REQ_TICK;
      else if (sel < 47) begin
         r.req_type = rrts_pkg::REQ_SLEEP;
         if ($urandom_range(3) != 0) r.sleep_quanta = 16'($urandom_range(6));
      end else if (sel < 62) begin
         r.req_type = rrts_pkg::REQ_BLOCK;
         if ($urandom_range(3) != 0) r.thread_id = live_tid();
      end else if (sel < 82) begin
         r.req_type = rrts_pkg::REQ_RESUME;
         if ($urandom_range(3) != 0) r.thread_id = live_tid();
      end else if (sel < 96) begin
         r.req_type = rrts_pkg::REQ_TERMINATE;
         if ($urandom_range(2) != 0) r.thread_id = live_tid();
         else if (r.thread_id == 0 && $urandom_range(7) != 0) r.thread_id = 4'd1;
      end
      return r;
   endfunction

   initial begin
      rrts_pkg::rsp_beat_type none;
      none = '0;
      sched_reset();
      add_row(mk(rrts_pkg::REQ_SLEEP, 4'd0, 32'd0, 16'd0), 1'b1,
              rs(rrts_pkg::STS_MAIN, 4'd0, 4'd0, 32'd1, 1'b0));
      add_row(mk(rrts_pkg::REQ_BLOCK, 4'd0, 32'd0, 16'd0), 1'b1,
              rs(rrts_pkg::STS_MAIN, 4'd0, 4'd0, 32'd1, 1'b0));
      add_row(mk(rrts_pkg::REQ_TERMINATE, 4'd15, 32'd0, 16'd0), 1'b1,
              rs(rrts_pkg::STS_NO_THREAD, 4'd0, 4'd0, 32'd1, 1'b0));
      add_row(mk(rrts_pkg::REQ_RESUME, 4'd7, 32'd0, 16'd0), 1'b1,
              rs(rrts_pkg::STS_NO_THREAD, 4'd0, 4'd0, 32'd1, 1'b0));
      add_row(mk(rrts_pkg::REQ_SPAWN, 4'd0, 32'd0, 16'd0), 1'b1,
              rs(rrts_pkg::STS_NULL, 4'd0, 4'd0, 32'd1, 1'b0));
      add_row(mk(rrts_pkg::REQ_RSVD6, 4'd0, 32'hFFFF_FFFF, 16'hFFFF), 1'b1,
              rs(rrts_pkg::STS_OK, 4'd0, 4'd0, 32'd1, 1'b0));
      add_row(mk(rrts_pkg::REQ_RSVD7, 4'd15, 32'd0, 16'd0), 1'b1,
              rs(rrts_pkg::STS_OK, 4'd0, 4'd0, 32'd1, 1'b0));
      add_row(mk(rrts_pkg::REQ_SPAWN, 4'd0, 32'hFFFF_FFFF, 16'd0), 1'b1,
              rs(rrts_pkg::STS_OK, 4'd1, 4'd0, 32'd1, 1'b0));
      add_row(mk(rrts_pkg::REQ_TICK, 4'd0, 32'd0, 16'd0), 1'b1,
              rs(rrts_pkg::STS_OK, 4'd0, 4'd1, 32'd2, 1'b0));
      // sleep of zero wakes in its own switch
      add_row(mk(rrts_pkg::REQ_SLEEP, 4'd0, 32'd0, 16'd0), 1'b0, none);
      add_row(mk(rrts_pkg::REQ_SLEEP, 4'd0, 32'd0, 16'hFFFF), 1'b0, none);
      add_row(mk(rrts_pkg::REQ_TICK, 4'd0, 32'd0, 16'd0), 1'b0, none);
      add_row(mk(rrts_pkg::REQ_BLOCK, 4'd1, 32'd0, 16'd0), 1'b0, none);
      add_row(mk(rrts_pkg::REQ_RESUME, 4'd1, 32'd0, 16'd0), 1'b0, none);
      add_row(mk(rrts_pkg::REQ_RESUME, 4'd1, 32'd0, 16'd0), 1'b0, none);
      for (int i = 0; i < 15; i++)
         add_row(mk(rrts_pkg::REQ_SPAWN, 4'd0, 32'(32'h1000 + i), 16'd0), 1'b0, none);
      add_row(mk(rrts_pkg::REQ_TERMINATE, 4'd1, 32'd0, 16'd0), 1'b0, none);
      add_row(mk(rrts_pkg::REQ_TERMINATE, 4'd0, 32'd0, 16'd0), 1'b1,
              rs(rrts_pkg::STS_OK, 4'd0, 4'd0, 32'd1, 1'b1));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rp);

      for (int n = 0; n < 2000; n++) begin
         if (n == 600) idle_on = 1'b0;
         if (n == 900) idle_on = 1'b1;
         if (n == 1200) begin
            req_valid <= 1'b0;
            while (rsp_expected_q.size() != 0) @(posedge clock);
         end
         send_request(random_request(), 1'b0, none);
      end
      req_valid <= 1'b0;
      while (rsp_expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && rsp_expected_q.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
